FILE: hw/rtl/status_field_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Status field parser assertion macros
// Implication checks on the local clk / rst_n; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef STATUS_FIELD_PARSER_UNIT_DEFINES_SVH
`define STATUS_FIELD_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SFP_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("status field parser assertion failed");
// next-cycle implication
`define SFP_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("status field parser assertion failed");
`else
`define SFP_ASSERT_IMP(lbl, cond, prop)
`define SFP_ASSERT_NXT(lbl, cond, prop)
`endif

`endif

FILE: hw/rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, character codes and helper functions of the status field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    localparam int NUM_SLOTS = 7;

    typedef logic [31:0] word_t;
    typedef logic [30:0] mag_t;
    typedef logic [2:0]  slot_t;

    typedef enum logic [2:0] {
        PH_LETTER = 3'b001,
        PH_SIGN   = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

    typedef struct packed {
        logic                         valid_res;
        logic [NUM_SLOTS-1:0][31:0]   vals;
    } sfp_result_t;

    localparam slot_t SLOT_S    = 3'd0;
    localparam slot_t SLOT_L    = 3'd1;
    localparam slot_t SLOT_T    = 3'd2;
    localparam slot_t SLOT_H    = 3'd3;
    localparam slot_t SLOT_A    = 3'd4;
    localparam slot_t SLOT_P    = 3'd5;
    localparam slot_t SLOT_F    = 3'd6;
    localparam slot_t SLOT_NONE = 3'd7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_F     = 8'h46;

    localparam mag_t MAG_MAX = 31'h7FFF_FFFF;

    function automatic slot_t slot_of(input logic [7:0] c);
        slot_t s;
        unique case (c)
            CH_S:    s = SLOT_S;
            CH_L:    s = SLOT_L;
            CH_T:    s = SLOT_T;
            CH_H:    s = SLOT_H;
            CH_A:    s = SLOT_A;
            CH_P:    s = SLOT_P;
            CH_F:    s = SLOT_F;
            default: s = SLOT_NONE;
        endcase
        return s;
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        logic [4:0] d;
        t = 8'h00;
        d = 5'h10;
        if (c >= CH_0 && c <= CH_9) begin
            t = c - CH_0;
            d = {1'b0, t[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            t = c - CH_UA + 8'd10;
            d = {1'b0, t[3:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            t = c - CH_LA + 8'd10;
            d = {1'b0, t[3:0]};
        end
        return d;
    endfunction

    function automatic word_t field_value(input logic neg, input mag_t mag);
        word_t v;
        v = {1'b0, mag};
        return neg ? (32'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sfp_core.sv
// ----------------------------------------------------------------------------
// sfp_core
// Per-beat field parse: phase, accumulator and status values, one byte a step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "status_field_parser_unit_defines.svh"

module sfp_core
    import sfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  ch,
    input  wire logic        last,
    output sfp_result_t      result
);

    phase_t                      phase_reg, phase_next;
    slot_t                       slot_reg, slot_next;
    logic                        neg_reg, neg_next;
    mag_t                        acc_reg, acc_next;
    logic                        seen_reg, seen_next;
    logic                        any_reg, any_next;
    logic                        mal_reg, mal_next;
    logic                        stop_reg, stop_next;
    logic [NUM_SLOTS-1:0][31:0]  vals_reg, vals_next;

    logic [4:0]  dv;
    logic        hex;
    logic        is_dig;
    logic [34:0] prod;
    logic [34:0] sum;
    mag_t        acc_step;
    logic        do_digits;

    assign dv       = digit_of(ch);
    assign hex      = (slot_reg == SLOT_S);
    assign is_dig   = !dv[4] && (hex || (dv[3:0] < 4'd10));
    assign prod     = hex ? {acc_reg, 4'b0000}
                          : ({1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0});
    assign sum      = prod + {31'd0, dv[3:0]};
    assign acc_step = (sum[34:31] != 4'd0) ? MAG_MAX : sum[30:0];

    always_comb
    begin
        phase_next = phase_reg;
        slot_next  = slot_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        any_next   = any_reg;
        mal_next   = mal_reg;
        stop_next  = stop_reg;
        vals_next  = vals_reg;
        do_digits  = 1'b0;

        if (step && !stop_reg)
        begin
            unique case (phase_reg)
                PH_SIGN:
                begin
                    phase_next = PH_DIGITS;
                    if (ch == CH_MINUS)
                        neg_next = 1'b1;
                    else
                        do_digits = 1'b1;
                end
                PH_DIGITS:
                    do_digits = 1'b1;
                default:
                begin
                    if (ch == CH_NUL)
                        stop_next = 1'b1;
                    else
                    begin
                        slot_next  = slot_of(ch);
                        neg_next   = 1'b0;
                        acc_next   = '0;
                        seen_next  = 1'b0;
                        phase_next = PH_SIGN;
                    end
                end
            endcase

            if (do_digits)
            begin
                if (is_dig)
                begin
                    acc_next  = acc_step;
                    seen_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_LETTER;
                    if (!seen_reg)
                    begin
                        mal_next  = 1'b1;
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (slot_reg == slot_t'(i))
                                vals_next[i] = field_value(neg_reg, acc_reg);
                        any_next = 1'b1;
                        if (ch == CH_NUL)
                            stop_next = 1'b1;
                        else if (ch != CH_COMMA)
                        begin
                            slot_next  = slot_of(ch);
                            neg_next   = 1'b0;
                            acc_next   = '0;
                            seen_next  = 1'b0;
                            phase_next = PH_SIGN;
                        end
                    end
                end
            end
        end

        // close an open field at end of payload
        if (step && last && !stop_next && phase_next != PH_LETTER)
        begin
            if (!seen_next)
                mal_next = 1'b1;
            else
            begin
                for (int j = 0; j < NUM_SLOTS; j++)
                    if (slot_next == slot_t'(j))
                        vals_next[j] = field_value(neg_next, acc_next);
                any_next = 1'b1;
            end
        end

        result.valid_res = any_next && !mal_next;
        result.vals      = vals_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LETTER;
            slot_reg  <= SLOT_NONE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            any_reg   <= 1'b0;
            mal_reg   <= 1'b0;
            stop_reg  <= 1'b0;
            vals_reg  <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg <= PH_LETTER;
                slot_reg  <= SLOT_NONE;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
                seen_reg  <= 1'b0;
                any_reg   <= 1'b0;
                mal_reg   <= 1'b0;
                stop_reg  <= 1'b0;
                vals_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                slot_reg  <= slot_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                seen_reg  <= seen_next;
                any_reg   <= any_next;
                mal_reg   <= mal_next;
                stop_reg  <= stop_next;
                vals_reg  <= vals_next;
            end
        end
    end

    `SFP_ASSERT_NXT(a_clear_after_last, step && last, phase_reg == PH_LETTER && !stop_reg && !any_reg)
    `SFP_ASSERT_IMP(a_malformed_stops, mal_reg, stop_reg)
    `SFP_ASSERT_NXT(a_stop_freezes, stop_reg && step && !last, stop_reg && $stable(acc_reg) && $stable(vals_reg))

endmodule

`default_nettype wire

FILE: hw/rtl/status_field_parser_unit.sv
// A byte accepted with last set passes the input and result registers to res_valid.
// One byte per cycle unless a last byte is held; the parse step is a multiply-add.
// A last byte waits in the input register only while an earlier result is stalled.
// Asynchronous reset (rst_n low) resets parse state, zeroes core status values.
// ----------------------------------------------------------------------------
// status_field_parser_unit
// Byte-serial status payload parser: input register, parse core, result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "status_field_parser_unit_defines.svh"

module status_field_parser_unit
    import sfp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         src_valid,
    output logic              src_stall,
    input  wire logic [7:0]   ch,
    input  wire logic         last,
    output logic              res_valid,
    input  wire logic         res_stall,
    output logic              valid_res,
    output logic signed [31:0] out_state_code,
    output logic signed [31:0] out_line,
    output logic signed [31:0] out_temp,
    output logic signed [31:0] out_pilot_h,
    output logic signed [31:0] out_amps,
    output logic signed [31:0] out_power,
    output logic signed [31:0] out_offline_limit
);

    logic         s1_valid_reg;
    logic [7:0]   s1_ch_reg;
    logic         s1_last_reg;
    logic         res_valid_reg;
    sfp_result_t  res_reg;
    sfp_result_t  core_res;
    logic         out_free;
    logic         proc;

    assign out_free  = !res_valid_reg || !res_stall;
    assign proc      = s1_valid_reg && (!s1_last_reg || out_free);
    assign src_stall = s1_valid_reg && !proc;

    sfp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (proc),
        .ch     (s1_ch_reg),
        .last   (s1_last_reg),
        .result (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || proc)
                s1_valid_reg <= src_valid;
            if (proc && s1_last_reg)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            s1_ch_reg   <= ch;
            s1_last_reg <= last;
        end
        if (proc && s1_last_reg)
            res_reg <= core_res;
    end

    assign res_valid         = res_valid_reg;
    assign valid_res         = res_reg.valid_res;
    assign out_state_code    = res_reg.vals[SLOT_S];
    assign out_line          = res_reg.vals[SLOT_L];
    assign out_temp          = res_reg.vals[SLOT_T];
    assign out_pilot_h       = res_reg.vals[SLOT_H];
    assign out_amps          = res_reg.vals[SLOT_A];
    assign out_power         = res_reg.vals[SLOT_P];
    assign out_offline_limit = res_reg.vals[SLOT_F];

    `SFP_ASSERT_NXT(a_res_loaded, proc && s1_last_reg, res_valid_reg)
    `SFP_ASSERT_IMP(a_no_overwrite, res_valid_reg && res_stall, !(proc && s1_last_reg))
    `SFP_ASSERT_IMP(a_stall_only_full, src_stall, s1_valid_reg && s1_last_reg && !out_free)

endmodule

`default_nettype wire

FILE: tb/sv/tb_status_field_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_status_field_parser_unit
// Drives status payloads one byte per beat, predicts each end-of-payload report
// from a local parser model and checks every report beat field by field, under
// sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_status_field_parser_unit;
    import sfp_pkg::*;

    localparam int          RESET_CYCLES  = 12;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          QUIET_LIMIT   = 3000;
    localparam int          HOLD_CYCLES   = 150;
    localparam int unsigned HEX_RADIX     = 16;
    localparam int unsigned DEC_RADIX     = 10;
    localparam int unsigned NOT_DIGIT     = 99;
    localparam int unsigned MAG_LIMIT     = 32'h7FFF_FFFF;
    localparam logic [7:0]  CH_UZ         = 8'h5A;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic                          ok;
        logic [NUM_SLOTS-1:0][31:0]    vals;
    } status_report_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        src_valid = 1'b0;
    logic [7:0]  ch        = 8'h00;
    logic        last      = 1'b0;
    logic        res_stall = 1'b0;
    logic        src_stall;
    logic        res_valid;
    logic        valid_res;
    logic signed [31:0] out_state_code;
    logic signed [31:0] out_line;
    logic signed [31:0] out_temp;
    logic signed [31:0] out_pilot_h;
    logic signed [31:0] out_amps;
    logic signed [31:0] out_power;
    logic signed [31:0] out_offline_limit;

    status_field_parser_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .src_valid         (src_valid),
        .src_stall         (src_stall),
        .ch                (ch),
        .last              (last),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .valid_res         (valid_res),
        .out_state_code    (out_state_code),
        .out_line          (out_line),
        .out_temp          (out_temp),
        .out_pilot_h       (out_pilot_h),
        .out_amps          (out_amps),
        .out_power         (out_power),
        .out_offline_limit (out_offline_limit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser model state
    phase_t                     parse_phase;
    logic [7:0]                 field_char;
    logic                       field_neg;
    int unsigned                field_mag;
    logic                       field_has_digit;
    logic                       got_field;
    logic                       bad_payload;
    logic                       parse_halted;
    logic [NUM_SLOTS-1:0][31:0] status_vals;

    status_report_t expected_reports [$];

    int src_gap_pct   = 0;
    int res_stall_pct = 0;
    int bytes_sent    = 0;
    int mismatches    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    logic [7:0] field_letters [NUM_SLOTS] = '{CH_S, CH_L, CH_T, CH_H, CH_A, CH_P, CH_F};
    string slot_names [NUM_SLOTS] = '{"out_state_code", "out_line", "out_temp",
        "out_pilot_h", "out_amps", "out_power", "out_offline_limit"};

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic void clear_parser();
        parse_phase     = PH_LETTER;
        field_char      = CH_NUL;
        field_neg       = 1'b0;
        field_mag       = 0;
        field_has_digit = 1'b0;
        got_field       = 1'b0;
        bad_payload     = 1'b0;
        parse_halted    = 1'b0;
        status_vals     = '0;
    endfunction

    function automatic slot_t status_slot(input logic [7:0] c);
        case (c)
            CH_S:    return SLOT_S;
            CH_L:    return SLOT_L;
            CH_T:    return SLOT_T;
            CH_H:    return SLOT_H;
            CH_A:    return SLOT_A;
            CH_P:    return SLOT_P;
            CH_F:    return SLOT_F;
            default: return SLOT_NONE;
        endcase
    endfunction

    function automatic void open_field(input logic [7:0] c);
        if (c == CH_NUL)
        begin
            parse_halted = 1'b1;
            return;
        end
        field_char      = c;
        field_neg       = 1'b0;
        field_mag       = 0;
        field_has_digit = 1'b0;
        parse_phase     = PH_SIGN;
    endfunction

    function automatic void close_field();
        slot_t s;
        parse_phase = PH_LETTER;
        if (!field_has_digit)
        begin
            bad_payload  = 1'b1;
            parse_halted = 1'b1;
            return;
        end
        s = status_slot(field_char);
        if (s != SLOT_NONE)
            status_vals[s] = field_neg ? (32'd0 - field_mag) : field_mag;
        got_field = 1'b1;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        int unsigned radix;
        int unsigned d;
        radix = (field_char == CH_S) ? HEX_RADIX : DEC_RADIX;
        if (c >= CH_0 && c <= CH_9)
            d = {24'd0, c - CH_0};
        else if (c >= CH_UA && c <= CH_UF)
            d = c - CH_UA + 10;
        else if (c >= CH_LA && c <= CH_LF)
            d = c - CH_LA + 10;
        else
            d = NOT_DIGIT;
        if (d < radix)
        begin
            if (field_mag > (MAG_LIMIT - d) / radix)
                field_mag = MAG_LIMIT;
            else
                field_mag = field_mag * radix + d;
            field_has_digit = 1'b1;
            return;
        end
        close_field();
        if (parse_halted)
            return;
        if (c == CH_COMMA)
            parse_phase = PH_LETTER;
        else
            open_field(c);
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic fin);
        status_report_t r;
        if (!parse_halted)
        begin
            case (parse_phase)
                PH_SIGN:
                begin
                    parse_phase = PH_DIGITS;
                    if (c == CH_MINUS)
                        field_neg = 1'b1;
                    else
                        take_digit(c);
                end
                PH_DIGITS: take_digit(c);
                default:   open_field(c);
            endcase
        end
        if (fin)
        begin
            if (!parse_halted && parse_phase != PH_LETTER)
                close_field();
            r.ok   = got_field && !bad_payload;
            r.vals = status_vals;
            expected_reports.push_back(r);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------------
    // payload generators
    // ------------------------------------------------------------------------
    function automatic logic [7:0] dec_char();
        return 8'(CH_0 + $urandom_range(9));
    endfunction

    function automatic logic [7:0] hex_char();
        int unsigned v;
        v = $urandom_range(21);
        if (v < 10)
            return 8'(CH_0 + v);
        else if (v < 16)
            return 8'(CH_LA + v - 10);
        return 8'(CH_UA + v - 16);
    endfunction

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t p;
        for (int i = 0; i < s.len(); i++)
            p.push_back(s[i]);
        return p;
    endfunction

    function automatic byte_q_t wellformed_payload();
        byte_q_t    p;
        logic [7:0] letter;
        int         fields;
        int         ndig;
        fields = $urandom_range(1, 5);
        for (int f = 0; f < fields; f++)
        begin
            if ($urandom_range(9) < 8)
                letter = field_letters[3'($urandom_range(NUM_SLOTS - 1))];
            else
                letter = 8'($urandom_range(CH_UA, CH_UZ));
            p.push_back(letter);
            if ($urandom_range(3) == 0)
                p.push_back(CH_MINUS);
            // long runs can push the magnitude into saturation
            ndig = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
            repeat (ndig)
                p.push_back((letter == CH_S) ? hex_char() : dec_char());
            if ($urandom_range(1))
                p.push_back(CH_COMMA);
        end
        if ($urandom_range(19) == 0)
        begin
            p.push_back(CH_NUL);
            p.push_back(8'($urandom_range(255)));
        end
        return p;
    endfunction

    function automatic byte_q_t broken_payload();
        byte_q_t p;
        int      k;
        p = wellformed_payload();
        k = $urandom_range(p.size() - 1);
        case ($urandom_range(2))
            0:       p = p[0:k];
            1:       p[k] = 8'($urandom_range(255));
            default: p.insert(k, $urandom_range(1) ? CH_MINUS : CH_COMMA);
        endcase
        return p;
    endfunction

    function automatic byte_q_t noise_payload();
        byte_q_t p;
        repeat ($urandom_range(1, 8))
            p.push_back(8'($urandom_range(255)));
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic fin, input bit paced);
        if (paced)
        begin
            while ($urandom_range(99) < src_gap_pct)
            begin
                src_valid <= 1'b0;
                @(posedge clk);
            end
        end
        src_valid <= 1'b1;
        ch        <= c;
        last      <= fin;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        predict_byte(c, fin);
        bytes_sent++;
    endtask

    task automatic send_payload(input byte_q_t p);
        bit paced;
        paced = ($urandom_range(7) != 0);
        foreach (p[i])
            send_byte(p[i], i == p.size() - 1, paced);
    endtask

    task automatic wait_for_reports();
        src_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_random_traffic(input int gap_pct, input int stall_pct, input int nbytes);
        int stop_at;
        int pick;
        src_gap_pct   = gap_pct;
        res_stall_pct = stall_pct;
        stop_at       = bytes_sent + nbytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_payload(wellformed_payload());
            else if (pick < 85)
                send_payload(broken_payload());
            else
                send_payload(noise_payload());
        end
        wait_for_reports();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_fields();
        byte_q_t p;
        src_gap_pct   = 0;
        res_stall_pct = 0;
        send_payload(text_bytes("SaF,L-9T1H2A3P4F5"));
        send_payload(text_bytes("Z-8,5"));
        send_payload(text_bytes("S-fffffffff"));
        send_payload(text_bytes("L1L2"));
        send_payload(text_bytes("T,L1"));
        p = text_bytes("T1");
        p.push_back(CH_NUL);
        p.push_back(CH_S);
        send_payload(p);
        p = {};
        p.push_back(CH_NUL);
        send_payload(p);
        wait_for_reports();
    endtask

    task automatic test_streaming();
        run_random_traffic(0, 0, 350);
    endtask

    task automatic test_sender_gaps();
        run_random_traffic(87, 0, 350);
    endtask

    task automatic test_receiver_stalls();
        run_random_traffic(0, 87, 350);
    endtask

    task automatic test_both_idle();
        run_random_traffic(32, 32, 350);
    endtask

    task automatic test_output_backpressure();
        src_gap_pct   = 0;
        res_stall_pct = 0;
        hold_requests++;
        repeat (15)
            send_payload(wellformed_payload());
        wait_for_reports();
    endtask

    // ------------------------------------------------------------------------
    // receiver, checker, watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            res_stall   <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < res_stall_pct);
    end

    always @(posedge clk)
    begin : check_reports
        status_report_t want;
        logic [31:0]    got [NUM_SLOTS];
        if (rst_n && res_valid && !res_stall)
        begin
            got = '{out_state_code, out_line, out_temp, out_pilot_h,
                    out_amps, out_power, out_offline_limit};
            if (expected_reports.size() == 0)
            begin
                $error("report beat with no report pending");
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (valid_res !== want.ok)
                begin
                    $error("valid_res: expected %0d, got %0d", want.ok, valid_res);
                    mismatches++;
                end
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (got[i] !== want.vals[i])
                    begin
                        $error("%s: expected %0d, got %0d", slot_names[i],
                               $signed(want.vals[i]), $signed(got[i]));
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL status_field_parser_unit");
                $finish;
            end
        end
    end

    initial
    begin
        clear_parser();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_fields();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_output_backpressure();
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("PASS status_field_parser_unit");
        else
            $display("FAIL status_field_parser_unit");
        $finish;
    end

endmodule
